FILE: rtl/core/nco_pkg.sv
package nco_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int CFG_BITS        = 32;

   localparam int TABLE_SIZE    = 1 << TABLE_ADDR_BITS;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int U_SHIFT       = 29 - TABLE_ADDR_BITS;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = QUEUE_PTR_BITS + 1;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_AMP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [PHASE_BITS-1:0]  STEP_RESET = PHASE_BITS'(32'd21474836);

   // Q30 polynomial coefficients for sin(pi/2*u)
   localparam logic [31:0] POLY_C1 = 32'd1686629713;
   localparam logic [31:0] POLY_C3 = 32'd693598668;
   localparam logic [31:0] POLY_C5 = 32'd85569306;
   localparam logic [31:0] POLY_C7 = 32'd5026997;
   localparam logic [31:0] POLY_C9 = 32'd172272;
   localparam logic [63:0] Q30_HALF = 64'd1 << 29;

   // table build operations, each a multiply step followed by a combine step
   localparam logic [2:0] OP_SQUARE  = 3'd0;
   localparam logic [2:0] OP_C7      = 3'd1;
   localparam logic [2:0] OP_C5      = 3'd2;
   localparam logic [2:0] OP_C3      = 3'd3;
   localparam logic [2:0] OP_C1      = 3'd4;
   localparam logic [2:0] OP_TIMES_U = 3'd5;
   localparam logic [2:0] OP_SCALE   = 3'd6;
   localparam logic [3:0] INIT_LAST_STEP = {OP_SCALE, 1'b1};

   typedef struct packed {
      logic [TABLE_ADDR_BITS-1:0] addr;
      logic                       negate;
      logic                       last;
   } nco_entry_type;

   typedef struct packed {
      logic                       en;
      logic [TABLE_ADDR_BITS-1:0] addr;
      logic [SAMPLE_BITS-1:0]     data;
   } nco_wr_type;

endpackage

FILE: rtl/core/nco_ram.sv
module nco_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/nco_init.sv
module nco_init
   import nco_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   output nco_wr_type wr,
   output logic       done
);

   logic [TABLE_ADDR_BITS-1:0] idx_ff, idx_in;
   logic [3:0]                 step_ff, step_in;
   logic                       done_ff, done_in;
   logic [63:0]                prod_ff, prod_in;
   logic [31:0]                u2_ff, u2_in;
   logic [31:0]                acc_ff, acc_in;

   logic [2:0]  op;
   logic [29:0] u;
   logic [31:0] mul_a, mul_b;
   logic [31:0] prod_q30;
   logic [33:0] rounded;

   assign op       = step_ff[3:1];
   assign u        = 30'({idx_ff, 1'b1}) << U_SHIFT;
   assign prod_q30 = prod_ff[61:30];
   assign rounded  = 34'((prod_ff + Q30_HALF) >> 30);

   always_comb begin
      case (op)
         OP_SQUARE: begin
            mul_a = 32'(u);
            mul_b = 32'(u);
         end
         OP_C7: begin
            mul_a = u2_ff;
            mul_b = POLY_C9;
         end
         OP_C5, OP_C3, OP_C1: begin
            mul_a = u2_ff;
            mul_b = acc_ff;
         end
         OP_TIMES_U: begin
            mul_a = 32'(u);
            mul_b = acc_ff;
         end
         OP_SCALE: begin
            mul_a = acc_ff;
            mul_b = 32'(SAMPLE_AMP);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      idx_in  = idx_ff;
      step_in = step_ff;
      done_in = done_ff;
      prod_in = prod_ff;
      u2_in   = u2_ff;
      acc_in  = acc_ff;
      wr.en   = 1'b0;
      wr.addr = idx_ff;
      wr.data = (rounded > 34'(SAMPLE_AMP)) ? SAMPLE_AMP : SAMPLE_BITS'(rounded);
      if (!done_ff) begin
         if (!step_ff[0]) begin
            prod_in = 64'(mul_a) * 64'(mul_b);
         end else begin
            case (op)
               OP_SQUARE:  u2_in  = prod_q30;
               OP_C7:      acc_in = POLY_C7 - prod_q30;
               OP_C5:      acc_in = POLY_C5 - prod_q30;
               OP_C3:      acc_in = POLY_C3 - prod_q30;
               OP_C1:      acc_in = POLY_C1 - prod_q30;
               OP_TIMES_U: acc_in = prod_q30;
               OP_SCALE:   wr.en  = 1'b1;
               default:    acc_in = acc_ff;
            endcase
         end
         if (step_ff == INIT_LAST_STEP) begin
            step_in = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == TABLE_ADDR_BITS'(TABLE_SIZE - 1)) begin
               done_in = 1'b1;
            end
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      u2_ff   <= u2_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("table build restarted");

   a_no_write_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !wr.en)
      else $error("table write after build finished");

endmodule

FILE: rtl/core/nco_front.sv
module nco_front
   import nco_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                init_done,
   input  logic                csr_wen,
   input  logic [CFG_BITS-1:0] csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_last,
   output logic                q_valid,
   output nco_entry_type       q_entry,
   input  logic                q_pop
);

   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [PHASE_BITS-1:0]     step_ff, step_in;
   nco_entry_type             q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   logic                       accept;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] k;
   nco_entry_type              push_entry;

   assign req_tready = init_done && (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   assign quad = phase_ff[PHASE_BITS-1 -: 2];
   assign k    = phase_ff[PHASE_BITS-3 -: TABLE_ADDR_BITS];

   always_comb begin
      push_entry.addr   = quad[0] ? ~k : k;
      push_entry.negate = quad[1];
      push_entry.last   = req_last;
      phase_in = accept ? phase_ff + step_ff : phase_ff;
      step_in  = csr_wen ? PHASE_BITS'(csr_wdata) : step_ff;
      count_in = count_ff + QUEUE_CNT_BITS'(accept) - QUEUE_CNT_BITS'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         step_ff   <= STEP_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_entry = q_mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_no_accept_during_build: assert property (@(posedge clock) disable iff (reset)
      accept |-> init_done)
      else $error("transaction accepted before table built");

endmodule

FILE: rtl/core/nco_back.sv
module nco_back
   import nco_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  nco_entry_type               q_entry,
   output logic                        q_pop,
   output logic                        rd_en,
   output logic [TABLE_ADDR_BITS-1:0]  rd_addr,
   input  logic [SAMPLE_BITS-1:0]      rd_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                        rsp_last
);

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_negate_ff;
   logic                   s1_last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                   out_last_ff;
   logic                   advance;

   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = q_valid && (!s1_valid_ff || advance);
   assign rd_en   = q_pop;
   assign rd_addr = q_entry.addr;

   always_comb begin
      s1_valid_in   = q_pop ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in  = advance ? s1_valid_ff : out_valid_ff;
      out_sample_in = s1_negate_ff ? SAMPLE_BITS'(~rd_data + 1'b1) : rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (q_pop) begin
         s1_negate_ff <= q_entry.negate;
         s1_last_ff   <= q_entry.last;
      end
      if (advance && s1_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("read stage dropped a transaction");

endmodule

FILE: rtl/core/sine_phase_accumulator_oscillator.sv
// A request accepted into the phase queue is read from the table and then
// registered at the output before it shows on rsp_tvalid. Throughput: one
// transaction per cycle while rsp_tready is high, limited by the single
// table read port. Reset: phase clears, tuning word returns to 21474836,
// and the quarter-wave table is swept and rebuilt while req_tready stays low.
module sine_phase_accumulator_oscillator
   import nco_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CFG_BITS-1:0]      csr_wdata,   // phase_step
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [0] last_request
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [SAMPLE_BITS-1:0] sample
   output logic                     rsp_tlast    // last_sample
);

   nco_wr_type                   tbl_wr;
   logic                         init_done;
   logic                         q_valid;
   nco_entry_type                q_entry;
   logic                         q_pop;
   logic                         rd_en;
   logic [TABLE_ADDR_BITS-1:0]   rd_addr;
   logic [SAMPLE_BITS-1:0]       rd_data;
   logic signed [SAMPLE_BITS-1:0] sample;

   nco_init u_init (
      .clock (clock),
      .reset (reset),
      .wr    (tbl_wr),
      .done  (init_done)
   );

   nco_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nco_front u_front (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_last   (req_tdata[0]),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   nco_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sample (sample),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'(unsigned'(sample));

endmodule

FILE: sim/tb_top.sv
module tb_top
   import nco_pkg::*;
;

   localparam longint unsigned SIN_C1 = 64'd1686629713;
   localparam longint unsigned SIN_C3 = 64'd693598668;
   localparam longint unsigned SIN_C5 = 64'd85569306;
   localparam longint unsigned SIN_C7 = 64'd5026997;
   localparam longint unsigned SIN_C9 = 64'd172272;
   localparam logic [PHASE_BITS-1:0] STEP_AT_RESET = 32'd21474836;
   localparam int CLOCK_HALF = 6;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
   } sample_rec_type;

   class sine_tracker;
      logic [PHASE_BITS-1:0]  phase;
      logic [PHASE_BITS-1:0]  step;
      logic [SAMPLE_BITS-1:0] quarter [TABLE_SIZE];
      sample_rec_type         pending_samples[$];
      int                     errors;

      function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
         return (a * b) >> 30;
      endfunction

      function new();
         longint unsigned u, u2, r, s, amp;
         amp = (64'd1 << (SAMPLE_BITS - 1)) - 1;
         phase = '0;
         step = STEP_AT_RESET;
         errors = 0;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            u = longint'(2 * i + 1) << (29 - TABLE_ADDR_BITS);
            u2 = q30_mul(u, u);
            r = SIN_C9;
            r = SIN_C7 - q30_mul(u2, r);
            r = SIN_C5 - q30_mul(u2, r);
            r = SIN_C3 - q30_mul(u2, r);
            r = SIN_C1 - q30_mul(u2, r);
            s = q30_mul(u, r);
            s = (s * amp + (64'd1 << 29)) >> 30;
            if (s > amp)
               s = amp;
            quarter[i] = SAMPLE_BITS'(s);
         end
      endfunction

      // sample of the current phase, then advance by the tuning word
      function void note_request(logic last);
         logic [1:0]                 quad;
         logic [TABLE_ADDR_BITS-1:0] k;
         logic [SAMPLE_BITS-1:0]     mag;
         sample_rec_type             rec;
         quad = phase[PHASE_BITS-1 -: 2];
         k = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
         if (quad[0])
            k = ~k;
         mag = quarter[k];
         rec.sample = quad[1] ? -mag : mag;
         rec.last = last;
         pending_samples.push_back(rec);
         phase = phase + step;
      endfunction

      function void check_sample(logic [SAMPLE_BITS-1:0] sample, logic last);
         sample_rec_type exp_rec;
         if (pending_samples.size() == 0) begin
            $error("sample: expected none, actual %0d", $signed(sample));
            errors++;
            return;
         end
         exp_rec = pending_samples.pop_front();
         if (sample !== exp_rec.sample) begin
            $error("sample: expected %0d, actual %0d", $signed(exp_rec.sample), $signed(sample));
            errors++;
         end
         if (last !== exp_rec.last) begin
            $error("last_sample: expected %0b, actual %0b", exp_rec.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     csr_wen = 1'b0;
   logic [CFG_BITS-1:0]      csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   bit          idle_on = 1'b1;
   int          sent_count = 0;
   sine_tracker tracker = new();

   sine_phase_accumulator_oscillator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #(2 * CLOCK_HALF * 600000);
      $display("sine_phase_accumulator_oscillator verification failed");
      $finish;
   end

   // result side: check each transaction, stall in random bursts while idle_on is set
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_sample(rsp_tdata[SAMPLE_BITS-1:0], rsp_tlast);
         if (hold > 0)
            hold--;
         else if (idle_on && $urandom_range(0, 4) == 0)
            hold = $urandom_range(1, 11);
         rsp_tready <= (hold == 0);
      end
   end

   task automatic wait_drained();
      for (int w = 0; w < 20000 && tracker.pending_samples.size() > 0; w++)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_step(logic [CFG_BITS-1:0] value);
      wait_drained();
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      tracker.step = value;
   endtask

   task automatic send_requests(int count, bit directed);
      logic [REQ_DATA_BITS-1:0] word;
      for (int i = 0; i < count; i++) begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         word = REQ_DATA_BITS'($urandom);
         word[0] = directed ? i[0] : ($urandom_range(0, 5) == 0);
         req_tvalid <= 1'b1;
         req_tdata <= word;
         do @(posedge clock); while (!req_tready);
         tracker.note_request(req_tdata[0]);
         sent_count++;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [CFG_BITS-1:0] value;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_requests(3, 1'b1);
      set_step(32'h4000_0000);
      send_requests(5, 1'b1);
      set_step(32'hFFFF_FFFF);
      send_requests(3, 1'b1);
      set_step(32'h0000_0000);
      send_requests(2, 1'b1);
      set_step(32'h8000_0000);
      send_requests(3, 1'b1);
      set_step(32'h0010_0000);
      send_requests(6, 1'b1);

      while (sent_count < 1400) begin
         case ($urandom_range(0, 4))
            0: value = $urandom;
            1: value = $urandom_range(1, 32'h0040_0000);
            2: value = 32'h0 - $urandom_range(1, 32'h0040_0000);
            3: begin
               case ($urandom_range(0, 2))
                  0: value = '0;
                  1: value = '1;
                  default: value = 32'h8000_0000;
               endcase
            end
            default: value = 32'd1 << $urandom_range(0, 31);
         endcase
         set_step(value);
         send_requests($urandom_range(20, 120), 1'b0);
      end

      wait_drained();
      idle_on = 1'b0;
      set_step($urandom);
      send_requests(150, 1'b0);
      wait_drained();

      if (tracker.pending_samples.size() > 0) begin
         $error("sample: expected %0d more transactions, actual none",
                tracker.pending_samples.size());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("sine_phase_accumulator_oscillator verification clean");
      else
         $display("sine_phase_accumulator_oscillator verification failed");
      $finish;
   end

endmodule
